// ===== sv/thtemp_pkg.sv =====
// thtemp_pkg: widths, constants, codes and the pipeline sideband type of the
// thermistor temperature converter; used by every module of the block
// no dependencies
package thtemp_pkg;

    // register and field widths
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int PULL_W  = 20;
    localparam int FS_W    = 16;
    localparam int CF_W    = 40;
    localparam int IDX_W   = 3;
    localparam int TEMP_W  = 16;
    localparam int ST_W    = 2;
    localparam int MODE_W  = 2;

    // internal datapath widths (sized for the widest sample)
    localparam int NUM_W   = PULL_W + 16;
    localparam int E_W     = 6;
    localparam int FRAC_W  = 30;
    localparam int LOG_W   = E_W + FRAC_W;
    localparam int Y_W     = FRAC_W + 1;
    localparam int LMAG_W  = 30;
    localparam int L2_W    = 36;
    localparam int L3_W    = 42;
    localparam int TB_W    = 46;
    localparam int TC_W    = 58;
    localparam int D_W     = 60;
    localparam int Q_W     = 59;
    localparam int C_W     = 30;
    localparam int M_W     = 32;
    localparam int V_W     = 32;

    // arithmetic constants
    localparam logic [23:0] LN2_Q24       = 24'd11629080;
    localparam int          ONE_SHIFT     = 56;
    localparam int          CEL_OFS_Q16   = 17901158;
    localparam int          FAHR_OFS_Q16  = 2097152;
    localparam int          CLAMP_Q16     = 268435456;
    localparam logic [31:0] RECIP5        = 32'hCCCCCCCD;
    localparam int          RECIP5_SHIFT  = 34;

    // status codes
    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_ZERO = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL = 2'd2;
    localparam logic [ST_W-1:0] ST_DEN  = 2'd3;

    // unit codes
    localparam logic [MODE_W-1:0] MODE_K = 2'd0;
    localparam logic [MODE_W-1:0] MODE_C = 2'd1;
    localparam logic [MODE_W-1:0] MODE_F = 2'd2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_PULLUP = 3'd0;
    localparam logic [IDX_W-1:0] REG_FS     = 3'd1;
    localparam logic [IDX_W-1:0] REG_COEFF_A = 3'd2;
    localparam logic [IDX_W-1:0] REG_COEFF_B = 3'd3;
    localparam logic [IDX_W-1:0] REG_COEFF_C = 3'd4;

    // register reset values
    localparam logic [PULL_W-1:0] RST_PULLUP = 20'd10000;
    localparam logic [FS_W-1:0]   RST_FS     = 16'd4095;
    localparam logic [CF_W-1:0]   RST_COEFF_A = -40'sd2428942;
    localparam logic [CF_W-1:0]   RST_COEFF_B = 40'sd772320057;
    localparam logic [CF_W-1:0]   RST_COEFF_C = 40'sd21932618;

    // sideband that travels with every item
    typedef struct packed {
        logic              vld;
        logic [MODE_W-1:0] mode;
        logic [ST_W-1:0]   err;
    } t_side;

endpackage

// ===== sv/thtemp_log_cell.sv =====
// thtemp_log_cell: one fraction bit of log2 for numerator and denominator
// by squaring the normalized mantissa; depends on thtemp_pkg
module thtemp_log_cell #(
    parameter int BIT = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  thtemp_pkg::t_side         i_side,
    input  logic [thtemp_pkg::Y_W-1:0]   i_yn,
    input  logic [thtemp_pkg::Y_W-1:0]   i_yd,
    input  logic [thtemp_pkg::LOG_W-1:0] i_rn,
    input  logic [thtemp_pkg::LOG_W-1:0] i_rd,
    output thtemp_pkg::t_side         o_side,
    output logic [thtemp_pkg::Y_W-1:0]   o_yn,
    output logic [thtemp_pkg::Y_W-1:0]   o_yd,
    output logic [thtemp_pkg::LOG_W-1:0] o_rn,
    output logic [thtemp_pkg::LOG_W-1:0] o_rd
);
    import thtemp_pkg::*;

    // square, keep Q1.30, renormalize when the square reaches two
    function automatic logic [Y_W:0] f_step(input logic [Y_W-1:0] y);
        logic [2*Y_W-1:0] sq;
        logic [Y_W:0]     t;
        sq = {{Y_W{1'b0}}, y} * {{Y_W{1'b0}}, y};
        t  = sq[2*Y_W-1:FRAC_W];
        return t[Y_W] ? {1'b1, t[Y_W:1]} : {1'b0, t[Y_W-1:0]};
    endfunction

    logic [Y_W:0] w_sn;
    logic [Y_W:0] w_sd;

    assign w_sn = f_step(i_yn);
    assign w_sd = f_step(i_yd);

    // sideband
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_side <= '0;
        end else if (i_en) begin
            o_side <= i_side;
        end
    end

    // mantissas and partial logs
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_yn <= w_sn[Y_W-1:0];
            o_yd <= w_sd[Y_W-1:0];
            o_rn <= i_rn | (w_sn[Y_W] ? (LOG_W'(1) << BIT) : '0);
            o_rd <= i_rd | (w_sd[Y_W] ? (LOG_W'(1) << BIT) : '0);
        end
    end

endmodule

// ===== sv/thtemp_div_cell.sv =====
// thtemp_div_cell: one quotient bit of the restoring reciprocal division
// depends on thtemp_pkg
module thtemp_div_cell #(
    parameter int K = 0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  thtemp_pkg::t_side        i_side,
    input  logic [thtemp_pkg::Q_W-1:0] i_d,
    input  logic [thtemp_pkg::Q_W-1:0] i_n,
    input  logic [thtemp_pkg::Q_W-1:0] i_r,
    input  logic [thtemp_pkg::Q_W-1:0] i_q,
    output thtemp_pkg::t_side        o_side,
    output logic [thtemp_pkg::Q_W-1:0] o_d,
    output logic [thtemp_pkg::Q_W-1:0] o_n,
    output logic [thtemp_pkg::Q_W-1:0] o_r,
    output logic [thtemp_pkg::Q_W-1:0] o_q
);
    import thtemp_pkg::*;

    logic [Q_W:0] w_rs;
    logic [Q_W:0] w_diff;
    logic         w_ge;

    // shift in the next dividend bit and try a subtract
    assign w_rs   = {i_r, i_n[K]};
    assign w_ge   = w_rs >= {1'b0, i_d};
    assign w_diff = w_rs - {1'b0, i_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_side <= '0;
        end else if (i_en) begin
            o_side <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_d <= i_d;
            o_n <= i_n;
            o_r <= w_ge ? w_diff[Q_W-1:0] : w_rs[Q_W-1:0];
            o_q <= {i_q[Q_W-2:0], w_ge};
        end
    end

endmodule

// ===== sv/thermistor_adc_to_temperature_core.sv =====
// Thermistor ADC sample to temperature by Steinhart-Hart. One item (sample, unit
// mode) is taken per clock unless the pipeline stalls; each result (temperature
// in 1/16 degree, status) passes divider-resistance setup, 30 log2 cells (one
// fraction bit each), log scaling and polynomial, 59 division cells (one quotient
// bit each), unit conversion and the output register. The output register holds
// a waiting result, so items keep entering while it waits until the next result
// reaches the last stage; then the whole pipeline stalls. The user must make
// configuration writes only while the block is idle; the block itself does not
// enforce this. Depends on thtemp_pkg, thtemp_log_cell, thtemp_div_cell
module thermistor_adc_to_temperature_core #(
    parameter int SAMPLE_BITS = thtemp_pkg::SAMPLE_BITS_DEF,
    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [thtemp_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [thtemp_pkg::CF_W-1:0]    i_cfg_wdata,
    // input items
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [TDATA_W-1:0]             i_s_axis_tdata,  // sample
    input  logic [thtemp_pkg::MODE_W-1:0]  i_s_axis_tuser,  // mode
    // result items
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [thtemp_pkg::TEMP_W-1:0]  o_m_axis_tdata,  // temperature
    output logic [thtemp_pkg::ST_W-1:0]    o_m_axis_tuser   // status
);
    import thtemp_pkg::*;

    localparam logic signed [D_W-1:0] LIM_HI = D_W'(CLAMP_Q16);
    localparam logic signed [D_W-1:0] LIM_LO = -LIM_HI;

    function automatic logic [E_W-1:0] f_msb(input logic [NUM_W-1:0] x);
        logic [E_W-1:0] p;
        p = '0;
        for (int i = 0; i < NUM_W; i++) begin
            if (x[i]) p = E_W'(i);
        end
        return p;
    endfunction

    // configuration registers
    logic [PULL_W-1:0] r_pullup;
    logic [FS_W-1:0]   r_fs;
    logic [CF_W-1:0]   r_coeff_a;
    logic [CF_W-1:0]   r_coeff_b;
    logic [CF_W-1:0]   r_coeff_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pullup  <= RST_PULLUP;
            r_fs      <= RST_FS;
            r_coeff_a <= RST_COEFF_A;
            r_coeff_b <= RST_COEFF_B;
            r_coeff_c <= RST_COEFF_C;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PULLUP:  r_pullup  <= i_cfg_wdata[PULL_W-1:0];
                REG_FS:      r_fs      <= i_cfg_wdata[FS_W-1:0];
                REG_COEFF_A: r_coeff_a <= i_cfg_wdata;
                REG_COEFF_B: r_coeff_b <= i_cfg_wdata;
                REG_COEFF_C: r_coeff_c <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline advance: stalls only when the last stage cannot drain
    t_side w_t3_side;
    logic  r_out_vld;
    logic  w_en;
    logic  w_acc;

    assign w_en            = !(w_t3_side.vld && r_out_vld && !i_m_axis_tready);
    assign w_acc           = i_s_axis_tvalid && w_en;
    assign o_s_axis_tready = w_en;

    // stage s0: resistance ratio terms and range checks
    logic [SAMPLE_BITS-1:0] w_sample;
    logic [ST_W-1:0]        w_s0_err;
    t_side                  r_s0;
    logic [NUM_W-1:0]       r_s0_num;
    logic [FS_W-1:0]        r_s0_den;

    assign w_sample = i_s_axis_tdata[SAMPLE_BITS-1:0];

    always_comb begin
        if (w_sample == '0) begin
            w_s0_err = ST_ZERO;
        end else if (FS_W'(w_sample) >= r_fs) begin
            w_s0_err = ST_FULL;
        end else begin
            w_s0_err = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0 <= '0;
        end else if (w_en) begin
            r_s0.vld  <= w_acc;
            r_s0.mode <= i_s_axis_tuser;
            r_s0.err  <= w_s0_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_num <= NUM_W'(r_pullup) * NUM_W'(w_sample);
            r_s0_den <= r_fs - FS_W'(w_sample);
        end
    end

    // stage s1: leading-one positions, zero resistance check
    t_side            r_s1;
    logic [E_W-1:0]   r_s1_en;
    logic [E_W-1:0]   r_s1_ed;
    logic [NUM_W-1:0] r_s1_num;
    logic [NUM_W-1:0] r_s1_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else if (w_en) begin
            r_s1.vld  <= r_s0.vld;
            r_s1.mode <= r_s0.mode;
            r_s1.err  <= (r_s0.err == ST_OK && r_s0_num == '0) ? ST_DEN : r_s0.err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_en  <= f_msb(r_s0_num);
            r_s1_ed  <= f_msb(NUM_W'(r_s0_den));
            r_s1_num <= r_s0_num;
            r_s1_den <= NUM_W'(r_s0_den);
        end
    end

    // stage s2: normalize mantissas to Q1.30
    logic [NUM_W-1:0] w_s2_nn;
    logic [NUM_W-1:0] w_s2_nd;

    assign w_s2_nn = r_s1_num << (E_W'(NUM_W - 1) - r_s1_en);
    assign w_s2_nd = r_s1_den << (E_W'(NUM_W - 1) - r_s1_ed);

    t_side            w_lside [0:FRAC_W];
    logic [Y_W-1:0]   w_lyn   [0:FRAC_W];
    logic [Y_W-1:0]   w_lyd   [0:FRAC_W];
    logic [LOG_W-1:0] w_lrn   [0:FRAC_W];
    logic [LOG_W-1:0] w_lrd   [0:FRAC_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            w_lside[0] <= '0;
        end else if (w_en) begin
            w_lside[0] <= r_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            w_lyn[0] <= w_s2_nn[NUM_W-1 -: Y_W];
            w_lyd[0] <= w_s2_nd[NUM_W-1 -: Y_W];
            w_lrn[0] <= {r_s1_en, {FRAC_W{1'b0}}};
            w_lrd[0] <= {r_s1_ed, {FRAC_W{1'b0}}};
        end
    end

    // log2 cell chain, most significant fraction bit first
    for (genvar g = 0; g < FRAC_W; g++) begin : g_log
        thtemp_log_cell #(.BIT(FRAC_W - 1 - g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_side  (w_lside[g]),
            .i_yn    (w_lyn[g]),
            .i_yd    (w_lyd[g]),
            .i_rn    (w_lrn[g]),
            .i_rd    (w_lrd[g]),
            .o_side  (w_lside[g+1]),
            .o_yn    (w_lyn[g+1]),
            .o_yd    (w_lyd[g+1]),
            .o_rn    (w_lrn[g+1]),
            .o_rd    (w_lrd[g+1])
        );
    end

    // stage m1: log2 difference as sign and magnitude
    logic [LOG_W:0]   w_m1_diff;
    t_side            r_m1;
    logic             r_m1_neg;
    logic [LOG_W-1:0] r_m1_mag;

    assign w_m1_diff = {1'b0, w_lrn[FRAC_W]} - {1'b0, w_lrd[FRAC_W]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1 <= '0;
        end else if (w_en) begin
            r_m1 <= w_lside[FRAC_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1_neg <= w_m1_diff[LOG_W];
            r_m1_mag <= w_m1_diff[LOG_W] ? LOG_W'(-w_m1_diff) : w_m1_diff[LOG_W-1:0];
        end
    end

    // stage m2: natural log in Q.24, rounded half away from zero
    logic [LOG_W+23:0] w_m2_prod;
    t_side             r_m2;
    logic              r_m2_neg;
    logic [LMAG_W-1:0] r_m2_l;

    assign w_m2_prod = (LOG_W+24)'(r_m1_mag) * (LOG_W+24)'(LN2_Q24)
                     + ((LOG_W+24)'(1) << (FRAC_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2 <= '0;
        end else if (w_en) begin
            r_m2 <= r_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m2_neg <= r_m1_neg;
            r_m2_l   <= w_m2_prod[FRAC_W +: LMAG_W];
        end
    end

    // stage m3: square of the log
    logic [2*LMAG_W-1:0] w_m3_prod;
    t_side               r_m3;
    logic                r_m3_neg;
    logic [LMAG_W-1:0]   r_m3_l;
    logic [L2_W-1:0]     r_m3_l2;

    assign w_m3_prod = (2*LMAG_W)'(r_m2_l) * (2*LMAG_W)'(r_m2_l);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m3 <= '0;
        end else if (w_en) begin
            r_m3 <= r_m2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m3_neg <= r_m2_neg;
            r_m3_l   <= r_m2_l;
            r_m3_l2  <= w_m3_prod[24 +: L2_W];
        end
    end

    // stage m4: cube of the log
    logic [L2_W+LMAG_W-1:0] w_m4_prod;
    t_side                  r_m4;
    logic                   r_m4_neg;
    logic [LMAG_W-1:0]      r_m4_l;
    logic [L3_W-1:0]        r_m4_l3;

    assign w_m4_prod = (L2_W+LMAG_W)'(r_m3_l2) * (L2_W+LMAG_W)'(r_m3_l);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m4 <= '0;
        end else if (w_en) begin
            r_m4 <= r_m3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m4_neg <= r_m3_neg;
            r_m4_l   <= r_m3_l;
            r_m4_l3  <= w_m4_prod[24 +: L3_W];
        end
    end

    // stage m5: coefficient partial products
    localparam int HB = CF_W / 2;
    localparam int HL = L3_W / 2;

    logic [CF_W-1:0] w_bmag;
    logic [CF_W-1:0] w_cmag;
    t_side           r_m5;
    logic            r_m5_sb;
    logic            r_m5_sc;
    logic [HB+LMAG_W-1:0] r_m5_pb0;
    logic [HB+LMAG_W-1:0] r_m5_pb1;
    logic [HB+HL-1:0]     r_m5_pc00;
    logic [HB+HL-1:0]     r_m5_pc01;
    logic [HB+HL-1:0]     r_m5_pc10;
    logic [HB+HL-1:0]     r_m5_pc11;

    assign w_bmag = r_coeff_b[CF_W-1] ? -r_coeff_b : r_coeff_b;
    assign w_cmag = r_coeff_c[CF_W-1] ? -r_coeff_c : r_coeff_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m5 <= '0;
        end else if (w_en) begin
            r_m5 <= r_m4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m5_sb   <= r_coeff_b[CF_W-1] ^ r_m4_neg;
            r_m5_sc   <= r_coeff_c[CF_W-1] ^ r_m4_neg;
            r_m5_pb0  <= (HB+LMAG_W)'(w_bmag[HB-1:0]) * (HB+LMAG_W)'(r_m4_l);
            r_m5_pb1  <= (HB+LMAG_W)'(w_bmag[CF_W-1:HB]) * (HB+LMAG_W)'(r_m4_l);
            r_m5_pc00 <= (HB+HL)'(w_cmag[HB-1:0]) * (HB+HL)'(r_m4_l3[HL-1:0]);
            r_m5_pc01 <= (HB+HL)'(w_cmag[HB-1:0]) * (HB+HL)'(r_m4_l3[L3_W-1:HL]);
            r_m5_pc10 <= (HB+HL)'(w_cmag[CF_W-1:HB]) * (HB+HL)'(r_m4_l3[HL-1:0]);
            r_m5_pc11 <= (HB+HL)'(w_cmag[CF_W-1:HB]) * (HB+HL)'(r_m4_l3[L3_W-1:HL]);
        end
    end

    // stage m6: sum partial products, scale to Q.40
    localparam int PB_W = CF_W + LMAG_W;
    localparam int PC_W = CF_W + L3_W;

    logic [PB_W-1:0] w_m6_b;
    logic [PC_W-1:0] w_m6_c;
    t_side           r_m6;
    logic            r_m6_sb;
    logic            r_m6_sc;
    logic [TB_W-1:0] r_m6_tb;
    logic [TC_W-1:0] r_m6_tc;

    assign w_m6_b = PB_W'(r_m5_pb0) + (PB_W'(r_m5_pb1) << HB);
    assign w_m6_c = PC_W'(r_m5_pc00) + (PC_W'(r_m5_pc01) << HL)
                  + (PC_W'(r_m5_pc10) << HB) + (PC_W'(r_m5_pc11) << (HB + HL));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m6 <= '0;
        end else if (w_en) begin
            r_m6 <= r_m5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m6_sb <= r_m5_sb;
            r_m6_sc <= r_m5_sc;
            r_m6_tb <= w_m6_b[24 +: TB_W];
            r_m6_tc <= w_m6_c[24 +: TC_W];
        end
    end

    // stage m7: Steinhart-Hart denominator, non-positive check
    logic [D_W-1:0] w_m7_tb;
    logic [D_W-1:0] w_m7_tc;
    logic [D_W-1:0] w_m7_d;
    t_side          r_m7;
    logic [D_W-1:0] r_m7_d;

    assign w_m7_tb = r_m6_sb ? -D_W'(r_m6_tb) : D_W'(r_m6_tb);
    assign w_m7_tc = r_m6_sc ? -D_W'(r_m6_tc) : D_W'(r_m6_tc);
    assign w_m7_d  = {{(D_W-CF_W){r_coeff_a[CF_W-1]}}, r_coeff_a} + w_m7_tb + w_m7_tc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m7 <= '0;
        end else if (w_en) begin
            r_m7.vld  <= r_m6.vld;
            r_m7.mode <= r_m6.mode;
            r_m7.err  <= (r_m6.err == ST_OK && (w_m7_d[D_W-1] || w_m7_d == '0))
                         ? ST_DEN : r_m6.err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m7_d <= w_m7_d;
        end
    end

    // stage m8: rounded reciprocal dividend
    t_side           w_dside [0:Q_W];
    logic [Q_W-1:0]  w_dd    [0:Q_W];
    logic [Q_W-1:0]  w_dn    [0:Q_W];
    logic [Q_W-1:0]  w_dr    [0:Q_W];
    logic [Q_W-1:0]  w_dq    [0:Q_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            w_dside[0] <= '0;
        end else if (w_en) begin
            w_dside[0] <= r_m7;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            w_dd[0] <= r_m7_d[Q_W-1:0];
            w_dn[0] <= (Q_W'(1) << ONE_SHIFT) + (r_m7_d[Q_W-1:0] >> 1);
            w_dr[0] <= '0;
            w_dq[0] <= '0;
        end
    end

    // division cell chain, quotient msb first
    for (genvar g = 0; g < Q_W; g++) begin : g_div
        thtemp_div_cell #(.K(Q_W - 1 - g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_side  (w_dside[g]),
            .i_d     (w_dd[g]),
            .i_n     (w_dn[g]),
            .i_r     (w_dr[g]),
            .i_q     (w_dq[g]),
            .o_side  (w_dside[g+1]),
            .o_d     (w_dd[g+1]),
            .o_n     (w_dn[g+1]),
            .o_r     (w_dr[g+1]),
            .o_q     (w_dq[g+1])
        );
    end

    // stage t1: unit offset and clamp to the range that still saturates alike
    logic signed [D_W-1:0] w_t1_v;
    t_side                 r_t1;
    logic [C_W-1:0]        r_t1_c;

    always_comb begin
        if (w_dside[Q_W].mode == MODE_C || w_dside[Q_W].mode == MODE_F) begin
            w_t1_v = $signed(D_W'(w_dq[Q_W])) - $signed(D_W'(CEL_OFS_Q16));
        end else begin
            w_t1_v = $signed(D_W'(w_dq[Q_W]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1 <= '0;
        end else if (w_en) begin
            r_t1 <= w_dside[Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            priority if (w_t1_v > LIM_HI) begin
                r_t1_c <= C_W'(LIM_HI);
            end else if (w_t1_v < LIM_LO) begin
                r_t1_c <= C_W'(LIM_LO);
            end else begin
                r_t1_c <= w_t1_v[C_W-1:0];
            end
        end
    end

    // stage t2: times nine on the magnitude
    logic [C_W-1:0] w_t2_mag;
    t_side          r_t2;
    logic           r_t2_neg;
    logic [C_W-1:0] r_t2_c;
    logic [M_W-1:0] r_t2_m;

    assign w_t2_mag = r_t1_c[C_W-1] ? -r_t1_c : r_t1_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t2 <= '0;
        end else if (w_en) begin
            r_t2 <= r_t1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t2_neg <= r_t1_c[C_W-1];
            r_t2_c   <= r_t1_c;
            r_t2_m   <= M_W'(w_t2_mag) * M_W'(9);
        end
    end

    // stage t3: divide by five through the reciprocal
    logic [2*M_W-1:0] w_t3_prod;
    t_side            r_t3;
    logic             r_t3_neg;
    logic [C_W-1:0]   r_t3_c;
    logic [C_W-1:0]   r_t3_q;

    assign w_t3_prod = (2*M_W)'(r_t2_m) * (2*M_W)'(RECIP5);
    assign w_t3_side = r_t3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t3 <= '0;
        end else if (w_en) begin
            r_t3 <= r_t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t3_neg <= r_t2_neg;
            r_t3_c   <= r_t2_c;
            r_t3_q   <= w_t3_prod[RECIP5_SHIFT +: C_W];
        end
    end

    // output stage: Fahrenheit offset, round to 1/16 degree, saturate
    logic signed [V_W-1:0] w_o_f;
    logic signed [V_W-1:0] w_o_v;
    logic signed [V_W-1:0] w_o_r;
    logic [TEMP_W-1:0]     w_o_temp;
    logic [TEMP_W-1:0]     r_out_temp;
    logic [ST_W-1:0]       r_out_st;

    assign w_o_f = r_t3_neg ? -$signed(V_W'(r_t3_q)) : $signed(V_W'(r_t3_q));
    assign w_o_v = (r_t3.mode == MODE_F) ? (w_o_f + $signed(V_W'(FAHR_OFS_Q16)))
                                         : $signed({{(V_W-C_W){r_t3_c[C_W-1]}}, r_t3_c});
    assign w_o_r = (w_o_v + $signed(V_W'(2048))) >>> 12;

    always_comb begin
        if (r_t3.err != ST_OK) begin
            w_o_temp = '0;
        end else if (w_o_r > $signed(V_W'(32767))) begin
            w_o_temp = 16'h7FFF;
        end else if (w_o_r < -$signed(V_W'(32768))) begin
            w_o_temp = 16'h8000;
        end else begin
            w_o_temp = w_o_r[TEMP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en && r_t3.vld) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_t3.vld) begin
            r_out_temp <= w_o_temp;
            r_out_st   <= r_t3.err;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_temp;
    assign o_m_axis_tuser  = r_out_st;

`ifndef SYNTHESIS
    // an error result always carries a zero temperature
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != ST_OK) |-> (o_m_axis_tdata == '0))
        else $error("error result with nonzero temperature");

    // no input taken while the pipeline end is blocked
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_t3.vld && r_out_vld && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input accepted while pipeline blocked");

    // mantissas enter the log chain normalized
    a_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_lside[0].vld && w_lside[0].err == ST_OK) |->
        (w_lyn[0][Y_W-1] && w_lyd[0][Y_W-1]))
        else $error("log mantissa not normalized");
`endif

endmodule
